// ===== rtl/fast_trig_polynomial_unit_macros.svh =====
`ifndef FAST_TRIG_POLYNOMIAL_UNIT_MACROS_SVH
`define FAST_TRIG_POLYNOMIAL_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define FTPU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ftpu check failed");

// next-cycle implication, off during reset
`define FTPU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ftpu check failed");

// checked in every cycle, reset included
`define FTPU_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ftpu check failed");

`endif

// ===== rtl/ftpu_pkg.sv =====
`default_nettype none

package ftpu_pkg;

  localparam int FRAC_BITS = 28;
  localparam int WORK_FRAC = 40;
  localparam int OUT_SHIFT = WORK_FRAC - FRAC_BITS;
  localparam int HORNER_LEN = 9;
  localparam int SQRT_STEPS = 4;
  localparam int SQRT_STAGES = 12;

  typedef logic signed [63:0] word_t;

  localparam word_t WORK_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam word_t ONE = 64'sd1 <<< WORK_FRAC;

  localparam logic [2:0] CMD_SIN  = 3'd0;
  localparam logic [2:0] CMD_COS  = 3'd1;
  localparam logic [2:0] CMD_TAN  = 3'd2;
  localparam logic [2:0] CMD_ASIN = 3'd3;
  localparam logic [2:0] CMD_ACOS = 3'd4;
  localparam logic [2:0] CMD_ATAN = 3'd5;

  function automatic word_t clampw(word_t v);
    word_t r;
    r = v;
    if (v > WORK_MAX) r = WORK_MAX;
    if (v < -WORK_MAX) r = -WORK_MAX;
    return r;
  endfunction

  // decimal mantissa * 10^-exp10 scaled by 2^WORK_FRAC, round half away
  function automatic word_t coef_value(longint mant, int exp10);
    logic [127:0] den;
    logic [127:0] num;
    logic [127:0] q;
    logic [127:0] r;
    logic         neg;
    int           i;
    neg = mant < 0;
    den = 128'd1;
    for (i = 0; i < exp10; i++) den = den * 128'd10;
    num = neg ? 128'(-mant) : 128'(mant);
    num = num << WORK_FRAC;
    q = '0;
    r = '0;
    for (i = 127; i >= 0; i--) begin
      r = {r[126:0], num[i]};
      q = {q[126:0], 1'b0};
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    if ((r << 1) >= den) q = q + 128'd1;
    return neg ? -word_t'(q[63:0]) : word_t'(q[63:0]);
  endfunction

  localparam word_t COEF [55] = '{
    coef_value(761, 5), coef_value(-16605, 5), coef_value(1, 0),
    coef_value(-239, 10), coef_value(27526, 10), coef_value(-198409, 9),
    coef_value(83333315, 10), coef_value(-1666666664, 10), coef_value(1, 0),
    coef_value(3705, 5), coef_value(-4967, 4), coef_value(1, 0),
    coef_value(-2605, 10), coef_value(247609, 10), coef_value(-13888397, 10),
    coef_value(416666418, 10), coef_value(-64'sd4999999963, 10), coef_value(1, 0),
    coef_value(2033, 4), coef_value(31755, 5), coef_value(1, 0),
    coef_value(95168091, 10), coef_value(2900525, 9), coef_value(245650893, 10),
    coef_value(533740603, 10), coef_value(1333923995, 10),
    coef_value(64'sd3333314036, 10), coef_value(1, 0),
    coef_value(-187293, 7), coef_value(742610, 7), coef_value(-2121144, 7),
    coef_value(15707288, 7),
    coef_value(-12624911, 10), coef_value(66700901, 10), coef_value(-170881256, 10),
    coef_value(308918810, 10), coef_value(-501743046, 10), coef_value(889789874, 10),
    coef_value(-64'sd2145988016, 10), coef_value(64'sd15707963050, 10),
    coef_value(208351, 7), coef_value(-85133, 6), coef_value(180141, 6),
    coef_value(-3302995, 7), coef_value(999866, 6),
    coef_value(28662257, 10), coef_value(-161657367, 10), coef_value(429096138, 10),
    coef_value(-752896400, 10), coef_value(1065626393, 10),
    coef_value(-1420889944, 10), coef_value(1999355085, 10),
    coef_value(-64'sd3333314528, 10), coef_value(1, 0),
    coef_value(64'sd15707963268, 10)
  };

  localparam int HALF_PI_IDX = 54;
  localparam word_t HALF_PI = COEF[HALF_PI_IDX];

  localparam logic [5:0] SET_START [16] = '{
    6'd0, 6'd3, 6'd9, 6'd12, 6'd18, 6'd21, 6'd28, 6'd32,
    6'd28, 6'd32, 6'd40, 6'd45, 6'd0, 6'd0, 6'd0, 6'd0
  };
  localparam logic [3:0] SET_LEN [16] = '{
    4'd3, 4'd6, 4'd3, 4'd6, 4'd3, 4'd7, 4'd4, 4'd8,
    4'd4, 4'd8, 4'd5, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9
  };

  // coefficient for horner slot j, short sets padded with leading zeros
  function automatic word_t coef_at(logic [2:0] cmd, logic precise, int j);
    logic [3:0] sel;
    int         k;
    word_t      v;
    sel = {cmd, precise};
    k = j - (HORNER_LEN - int'(SET_LEN[sel]));
    v = '0;
    if (cmd <= CMD_ATAN && k >= 0) v = COEF[6'(int'(SET_START[sel]) + k)];
    return v;
  endfunction

  function automatic logic [31:0] to_output(word_t w);
    logic [63:0] m;
    logic [31:0] r;
    m = w[63] ? 64'(-w) : 64'(w);
    m = (m + (64'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
    if (w[63]) r = (m > 64'h8000_0000) ? 32'h8000_0000 : 32'(-m);
    else r = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ftpu_in_if.sv =====
`default_nettype none

interface ftpu_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic               precise;
  logic signed [31:0] operand;

  modport source (output valid, output cmd, output precise, output operand, input ready);
  modport sink (input valid, input cmd, input precise, input operand, output ready);
endinterface

`default_nettype wire

// ===== rtl/ftpu_out_if.sv =====
`default_nettype none

interface ftpu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/fast_trig_polynomial_unit.sv =====
// Polynomial sin/cos/tan/asin/acos/atan evaluator, signed Q3.28 in and out.
// in_ch carries cmd, precise and operand; out_ch carries the result value.
// A beat is taken whenever in_ch.valid and in_ch.ready are high at a clock edge.
// The datapath is a fixed 22-stage pipeline plus the output register: a
// squaring multiply, eight Horner multiply-add steps and a final multiply, each
// a two-stage 32x32 partial-product unit, with a 12-stage square root for
// asin/acos running alongside, then a post-adjust and a rounding stage.
// Throughput: one beat per cycle while out_ch.ready stays high.
// All stages advance together; when the receiver holds out_ch.ready low with a
// beat waiting, the whole pipeline freezes and in_ch.ready drops, so nothing is
// lost or repeated. Bubbles ahead of the output register stay put while frozen.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not
// reset. Selector codes 6 and 7 return zero.
`default_nettype none

module fast_trig_polynomial_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ftpu_in_if.sink    in_ch,
  ftpu_out_if.source out_ch
);

  localparam int NST  = 22;
  localparam int NMAC = 10;

  typedef struct packed {
    logic [2:0]      cmd;
    logic            precise;
    ftpu_pkg::word_t x;
    ftpu_pkg::word_t arg;
    ftpu_pkg::word_t root;
  } side_t;

  side_t           side_r   [NST];
  side_t           side_nxt [NST];
  logic [NST-1:0]  valid_r;
  logic            out_valid_r;
  logic [31:0]     out_value_r;
  ftpu_pkg::word_t res_r;
  ftpu_pkg::word_t res_nxt;
  ftpu_pkg::word_t arg_nxt;
  ftpu_pkg::word_t root_w;
  ftpu_pkg::word_t x_in;
  ftpu_pkg::word_t a_w [NMAC];
  ftpu_pkg::word_t b_w [NMAC];
  ftpu_pkg::word_t c_w [NMAC];
  ftpu_pkg::word_t y_w [NMAC];
  logic            en;
  logic            root_cmd;

  assign en = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  assign x_in = ftpu_pkg::word_t'(in_ch.operand) <<< ftpu_pkg::OUT_SHIFT;

  assign arg_nxt = (side_r[2].cmd == ftpu_pkg::CMD_ASIN || side_r[2].cmd == ftpu_pkg::CMD_ACOS)
                   ? side_r[2].x : y_w[0];

  always_comb begin
    side_nxt[0] = '{cmd: in_ch.cmd, precise: in_ch.precise, x: x_in, arg: '0, root: '0};
    for (int k = 1; k < NST; k++) side_nxt[k] = side_r[k-1];
    side_nxt[3].arg   = arg_nxt;
    side_nxt[13].root = root_w;
  end

  assign root_cmd = side_r[18].cmd == ftpu_pkg::CMD_ASIN ||
                    side_r[18].cmd == ftpu_pkg::CMD_ACOS;

  // mac 0 squares, 1..8 run horner, 9 applies the outer factor
  always_comb begin
    a_w[0] = side_r[0].x;
    b_w[0] = side_r[0].x;
    c_w[0] = '0;
    a_w[1] = ftpu_pkg::coef_at(side_r[2].cmd, side_r[2].precise, 0);
    b_w[1] = arg_nxt;
    c_w[1] = ftpu_pkg::coef_at(side_r[2].cmd, side_r[2].precise, 1);
    for (int j = 2; j < NMAC - 1; j++) begin
      a_w[j] = y_w[j-1];
      b_w[j] = side_r[2*j].arg;
      c_w[j] = ftpu_pkg::coef_at(side_r[2*j].cmd, side_r[2*j].precise, j);
    end
    a_w[NMAC-1] = y_w[NMAC-2];
    if (side_r[18].cmd == ftpu_pkg::CMD_COS) b_w[NMAC-1] = ftpu_pkg::ONE;
    else if (root_cmd) b_w[NMAC-1] = side_r[18].root;
    else b_w[NMAC-1] = side_r[18].x;
    c_w[NMAC-1] = '0;
  end

  for (genvar j = 0; j < NMAC; j++) begin : g_mac
    ftpu_mac u_mac (
      .clk (clk),
      .en  (en),
      .a   (a_w[j]),
      .b   (b_w[j]),
      .c   (c_w[j]),
      .y   (y_w[j])
    );
  end

  ftpu_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .x    (side_r[0].x),
    .root (root_w)
  );

  always_comb begin
    case (side_r[20].cmd)
      ftpu_pkg::CMD_SIN, ftpu_pkg::CMD_COS, ftpu_pkg::CMD_TAN,
      ftpu_pkg::CMD_ACOS, ftpu_pkg::CMD_ATAN: res_nxt = y_w[NMAC-1];
      ftpu_pkg::CMD_ASIN: res_nxt = ftpu_pkg::clampw(ftpu_pkg::HALF_PI - y_w[NMAC-1]);
      default: res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      valid_r     <= {valid_r[NST-2:0], in_ch.valid};
      out_valid_r <= valid_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NST; k++) side_r[k] <= side_nxt[k];
      res_r       <= res_nxt;
      out_value_r <= ftpu_pkg::to_output(res_r);
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.value = out_value_r;

endmodule

`default_nettype wire

// ===== rtl/ftpu_mac.sv =====
`default_nettype none

module ftpu_mac (
  input  wire logic          clk,
  input  wire logic          en,
  input  ftpu_pkg::word_t    a,
  input  ftpu_pkg::word_t    b,
  input  ftpu_pkg::word_t    c,
  output ftpu_pkg::word_t    y
);

  logic [63:0]     ua;
  logic [63:0]     ub;
  logic [63:0]     p00_r, p01_r, p10_r, p11_r;
  logic            neg_r;
  ftpu_pkg::word_t c_r;
  logic [127:0]    full;
  logic [61:0]     mag;
  ftpu_pkg::word_t prod;
  ftpu_pkg::word_t y_r;
  ftpu_pkg::word_t y_nxt;

  assign ua = a[63] ? 64'(-a) : 64'(a);
  assign ub = b[63] ? 64'(-b) : 64'(b);

  // partial products
  always_ff @(posedge clk) begin
    if (en) begin
      p00_r <= ua[31:0] * ub[31:0];
      p01_r <= ua[31:0] * ub[63:32];
      p10_r <= ua[63:32] * ub[31:0];
      p11_r <= ua[63:32] * ub[63:32];
      neg_r <= a[63] ^ b[63];
      c_r   <= c;
    end
  end

  // combine, round, saturate, accumulate
  always_comb begin
    full = {64'd0, p00_r} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0}
         + {p11_r, 64'd0} + (128'd1 << (ftpu_pkg::WORK_FRAC - 1));
    mag = (full[127:102] != '0) ? '1 : full[101:40];
    prod = neg_r ? -ftpu_pkg::word_t'({2'b00, mag}) : ftpu_pkg::word_t'({2'b00, mag});
    y_nxt = ftpu_pkg::clampw(prod + c_r);
  end

  always_ff @(posedge clk) begin
    if (en) y_r <= y_nxt;
  end

  assign y = y_r;

endmodule

`default_nettype wire

// ===== rtl/ftpu_sqrt.sv =====
`default_nettype none

module ftpu_sqrt (
  input  wire logic       clk,
  input  wire logic       en,
  input  ftpu_pkg::word_t x,
  output ftpu_pkg::word_t root
);

  localparam int ST = ftpu_pkg::SQRT_STAGES;
  localparam int NS = ftpu_pkg::SQRT_STEPS;

  ftpu_pkg::word_t diff;
  logic [63:0]     mag;
  logic [95:0]     rad0;
  logic [95:0]     rad_r  [ST];
  logic [51:0]     rem_r  [ST];
  logic [47:0]     root_r [ST];

  assign diff = ftpu_pkg::ONE - x;
  assign mag  = diff[63] ? 64'(-diff) : 64'(diff);
  assign rad0 = 96'(mag) << ftpu_pkg::WORK_FRAC;

  for (genvar s = 0; s < ST; s++) begin : g_stage
    logic [95:0] rad_i;
    logic [51:0] rem_i;
    logic [47:0] root_i;
    logic [51:0] rem_v;
    logic [47:0] root_v;

    if (s == 0) begin : g_first
      assign rad_i  = rad0;
      assign rem_i  = '0;
      assign root_i = '0;
    end else begin : g_next
      assign rad_i  = rad_r[s-1];
      assign rem_i  = rem_r[s-1];
      assign root_i = root_r[s-1];
    end

    always_comb begin
      logic [51:0] trial;
      int          i;
      rem_v  = rem_i;
      root_v = root_i;
      for (int t = 0; t < NS; t++) begin
        i = 47 - NS * s - t;
        rem_v = {rem_v[49:0], rad_i[2*i+1 -: 2]};
        trial = {2'b00, root_v, 2'b01};
        if (rem_v >= trial) begin
          rem_v  = rem_v - trial;
          root_v = {root_v[46:0], 1'b1};
        end else begin
          root_v = {root_v[46:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[s]  <= rad_i;
        rem_r[s]  <= rem_v;
        root_r[s] <= root_v;
      end
    end
  end

  assign root = ftpu_pkg::word_t'({16'd0, root_r[ST-1]});

endmodule

`default_nettype wire

// ===== rtl/ftpu_checker.sv =====
`default_nettype none
`include "fast_trig_polynomial_unit_macros.svh"

module ftpu_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_value
);

  `FTPU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value))
  `FTPU_ASSERT_ALWAYS(a_reset_clears, !rst_n, !out_valid)
  `FTPU_ASSERT_NOW(a_ready_follows_out, 1'b1, in_ready == (!out_valid || out_ready))

endmodule

bind fast_trig_polynomial_unit ftpu_checker u_ftpu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.value)
);

`default_nettype wire
